// File: rtl/core/crs_pkg.sv
// Shared constants, types and codes of the CSV record splitter.
package crs_pkg;

	localparam int MAX_COLUMNS      = 64;
	localparam int MAX_RECORD_BYTES = 4096;
	localparam int QUEUE_DEPTH      = 2;

	localparam int BYTE_W = 8;
	localparam int COL_W  = 7;
	localparam int OFF_W  = $clog2(MAX_RECORD_BYTES);
	localparam int CNT_W  = $clog2(MAX_COLUMNS + 2);

	localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

	localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd44;
	localparam logic [COL_W-1:0]  EXPECTED_RESET  = 7'd1;

	typedef enum logic [1:0] {
		PS_START    = 2'd0,
		PS_QUOTED   = 2'd1,
		PS_UNQUOTED = 2'd2,
		PS_AFTERQ   = 2'd3
	} parse_state_t;

	typedef enum logic [2:0] {
		ST_OPEN = 3'd0,
		ST_OK   = 3'd1,
		ST_MFQ  = 3'd2,
		ST_NTP  = 3'd3,
		ST_QNA  = 3'd4,
		ST_FEW  = 3'd5,
		ST_MANY = 3'd6
	} status_t;

	typedef enum logic {
		CFG_DELIMITER = 1'b0,
		CFG_EXPECTED  = 1'b1
	} cfg_index_t;

	// One classified input byte as it waits in the queue.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              is_last;
		logic              is_quote;
		logic              is_newline;
		logic              is_delim;
	} entry_t;

	// One result word before it is packed onto the output bus.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              field_start;
		logic [COL_W-1:0]  column_index;
		logic [OFF_W-1:0]  byte_offset;
		logic              record_done;
		status_t           status;
	} result_t;

endpackage

// File: rtl/core/crs_front.sv
// Front end: configuration registers and byte classification.
module crs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [crs_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [crs_pkg::BYTE_W-1:0]       s_tdata,
	input  logic                             s_tlast,
	output logic                             push_valid,
	input  logic                             push_ready,
	output crs_pkg::entry_t                  push_entry,
	output logic [crs_pkg::COL_W-1:0]        expected_columns
);

	logic [crs_pkg::BYTE_W-1:0] delimiter_q;
	logic [crs_pkg::COL_W-1:0]  expected_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= crs_pkg::DELIMITER_RESET;
			expected_q  <= crs_pkg::EXPECTED_RESET;
		end else if (cfg_valid) begin
			unique case (crs_pkg::cfg_index_t'(cfg_index))
				crs_pkg::CFG_DELIMITER: delimiter_q <= cfg_data;
				crs_pkg::CFG_EXPECTED:  expected_q  <= cfg_data[crs_pkg::COL_W-1:0];
			endcase
		end
	end

	assign expected_columns = expected_q;

	// Comparisons are made here so that the parser sees only flags.
	always_comb begin
		push_entry.data_byte  = s_tdata;
		push_entry.is_last    = s_tlast;
		push_entry.is_quote   = (s_tdata == crs_pkg::CH_QUOTE);
		push_entry.is_newline = (s_tdata == crs_pkg::CH_NEWLINE);
		push_entry.is_delim   = (s_tdata == delimiter_q);
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule

// File: rtl/core/crs_queue.sv
// Short queue of classified bytes between the front end and the parser.
module crs_queue #(
	parameter int DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  crs_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output crs_pkg::entry_t pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	crs_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/crs_back.sv
// Back end: the field parser, its counters and the output register.
module crs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	output logic                       head_ready,
	input  crs_pkg::entry_t            head,
	input  logic [crs_pkg::COL_W-1:0]  expected_columns,
	output logic                       res_valid,
	input  logic                       res_ready,
	output crs_pkg::result_t           res
);

	localparam int CNT_W = crs_pkg::CNT_W;
	localparam int OFF_W = crs_pkg::OFF_W;
	localparam logic [CNT_W-1:0] CC_MAX  = CNT_W'(crs_pkg::MAX_COLUMNS + 1);
	localparam logic [CNT_W-1:0] COL_MAX = CNT_W'(crs_pkg::MAX_COLUMNS);
	localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(crs_pkg::MAX_RECORD_BYTES - 1);

	crs_pkg::parse_state_t state_q;
	crs_pkg::parse_state_t state_step;
	crs_pkg::parse_state_t state_d;
	logic [CNT_W-1:0]      cc_q;
	logic [CNT_W-1:0]      cc_step;
	logic [OFF_W-1:0]      off_q;
	logic                  skip_q;
	logic                  valid_q;
	crs_pkg::result_t      res_q;
	crs_pkg::result_t      res_d;

	crs_pkg::status_t      err;
	logic                  ended;
	logic                  zero_byte;
	logic                  done;
	logic [CNT_W-1:0]      exp_eff;
	logic [CNT_W-1:0]      cur_col;
	logic                  pop;

	assign head_ready = !valid_q || res_ready;
	assign pop        = head_valid && head_ready;

	assign exp_eff = (expected_columns > crs_pkg::COL_W'(crs_pkg::MAX_COLUMNS)) ?
		COL_MAX : CNT_W'(expected_columns);
	assign cur_col = (cc_q == '0) ? '0 :
		(((cc_q - 1'b1) > COL_MAX) ? COL_MAX : cc_q - 1'b1);

	// Per-state decode of the head byte.
	always_comb begin
		state_step = state_q;
		err        = crs_pkg::ST_OPEN;
		ended      = 1'b0;
		zero_byte  = 1'b0;
		unique case (state_q)
			crs_pkg::PS_START: begin
				if (head.is_quote) begin
					state_step = crs_pkg::PS_QUOTED;
				end else if (head.is_newline) begin
					zero_byte = 1'b1;
					ended     = 1'b1;
				end else if (head.is_delim) begin
					zero_byte = 1'b1;
				end else begin
					state_step = crs_pkg::PS_UNQUOTED;
				end
			end
			crs_pkg::PS_QUOTED: begin
				if (head.is_newline) begin
					err = crs_pkg::ST_MFQ;
				end else if (head.is_quote) begin
					state_step = crs_pkg::PS_AFTERQ;
				end
			end
			crs_pkg::PS_UNQUOTED: begin
				if (head.is_delim) begin
					zero_byte  = 1'b1;
					state_step = crs_pkg::PS_START;
				end else if (head.is_newline) begin
					zero_byte = 1'b1;
					ended     = 1'b1;
				end else if (head.is_quote) begin
					err = crs_pkg::ST_QNA;
				end
			end
			crs_pkg::PS_AFTERQ: begin
				if (head.is_delim) begin
					zero_byte  = 1'b1;
					state_step = crs_pkg::PS_START;
				end else if (head.is_newline) begin
					zero_byte = 1'b1;
					ended     = 1'b1;
				end else if (head.is_quote) begin
					state_step = crs_pkg::PS_QUOTED;
				end else begin
					err = crs_pkg::ST_NTP;
				end
			end
		endcase
		if (err == crs_pkg::ST_OPEN && !ended && head.is_last) begin
			ended = 1'b1;
			if (state_step == crs_pkg::PS_QUOTED) begin
				err = crs_pkg::ST_MFQ;
			end
		end
		cc_step = ((state_q == crs_pkg::PS_START) && (cc_q < CC_MAX)) ? cc_q + 1'b1 : cc_q;
		done    = (err != crs_pkg::ST_OPEN) || ended;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		if (skip_q) begin
			state_d = crs_pkg::PS_START;
		end else if (done) begin
			state_d = crs_pkg::PS_START;
		end else begin
			state_d = state_step;
		end
	end

	// Result word for the head byte.
	always_comb begin
		res_d.out_byte     = head.data_byte;
		res_d.field_start  = 1'b0;
		res_d.column_index = crs_pkg::COL_W'(cur_col);
		res_d.byte_offset  = off_q;
		res_d.record_done  = 1'b0;
		res_d.status       = crs_pkg::ST_OPEN;
		if (!skip_q) begin
			if (zero_byte) begin
				res_d.out_byte = '0;
			end
			if (state_q == crs_pkg::PS_START) begin
				res_d.column_index = crs_pkg::COL_W'((cc_q > COL_MAX) ? COL_MAX : cc_q);
				res_d.field_start  = (cc_q < exp_eff);
			end
			res_d.record_done = done;
			if (err != crs_pkg::ST_OPEN) begin
				res_d.status = err;
			end else if (ended) begin
				if (cc_step < exp_eff) begin
					res_d.status = crs_pkg::ST_FEW;
				end else if (cc_step > exp_eff) begin
					res_d.status = crs_pkg::ST_MANY;
				end else begin
					res_d.status = crs_pkg::ST_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crs_pkg::PS_START;
			cc_q    <= '0;
			off_q   <= '0;
			skip_q  <= 1'b0;
		end else if (pop) begin
			state_q <= state_d;
			if (skip_q) begin
				if (head.is_newline || head.is_last) begin
					skip_q <= 1'b0;
					cc_q   <= '0;
					off_q  <= '0;
				end else if (off_q < OFF_MAX) begin
					off_q <= off_q + 1'b1;
				end
			end else if (done) begin
				skip_q <= (err != crs_pkg::ST_OPEN) && !head.is_last && !head.is_newline;
				cc_q   <= '0;
				off_q  <= '0;
			end else begin
				cc_q <= cc_step;
				if (off_q < OFF_MAX) begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (head_ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.record_done |-> res_q.status != crs_pkg::ST_OPEN)
		else $error("finished record carries no status");

	a_open_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.record_done |-> res_q.status == crs_pkg::ST_OPEN)
		else $error("status given on a byte that ends nothing");

	a_skip_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> state_q == crs_pkg::PS_START)
		else $error("parser left the start state while skipping");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= CC_MAX)
		else $error("column count beyond its saturation value");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skip_q |=> !res_q.field_start && !res_q.record_done)
		else $error("skipped byte reported as field start or record end");

endmodule

// File: rtl/core/csv_record_splitter.sv
// Top level of the CSV record splitter: front end, queue and parser.
//
//  channel  | direction | ports                              | word
//  ---------+-----------+------------------------------------+-------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tlast  | one record byte, last marker
//  m_       | out       | m_tvalid m_tready m_tdata m_tlast  | one parsed byte with position
//           |           | m_tuser                            | and status
//  cfg_     | in        | cfg_valid cfg_ready cfg_index      | register write
//           |           | cfg_data                           |
//
// One word is taken and one word is given per clock cycle in steady flow; the
// parser updates its state from the byte at the head of the queue. An accepted
// byte is written into the queue memory and moves into the output register when
// the parser pops it, so it passes both registers before it is on the output.
// Reset is asynchronous and active low; it clears the parser, counters, queue
// and output valid, and loads the delimiter with a comma and the expected
// column count with one. No clearing pass follows reset.
// A stall on the output side holds the result register and fills the queue;
// the input stalls only once the queue is full. The configuration port is
// always ready and must be written only while the block is empty.
module csv_record_splitter #(
	parameter int QUEUE_DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [14:8] column_index,
	                               // [26:15] byte_offset, [31:27] zero
	output logic        m_tlast,   // record_done
	output logic [3:0]  m_tuser,   // [0] field_start, [3:1] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	crs_pkg::entry_t              push_entry;
	crs_pkg::entry_t              head;
	crs_pkg::result_t             res;
	logic                         push_valid;
	logic                         push_ready;
	logic                         head_valid;
	logic                         head_ready;
	logic [crs_pkg::COL_W-1:0]    expected_columns;

	// The front end holds the registers and classifies each byte against the
	// quote, newline and the current delimiter.
	crs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_entry       (push_entry),
		.expected_columns (expected_columns)
	);

	// The queue lets the input keep flowing while a result waits downstream.
	crs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_entry  (head)
	);

	// The parser follows the field state, counts columns and offsets and checks
	// each record that ends without a quoting error against the expected column count.
	crs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_ready       (head_ready),
		.head             (head),
		.expected_columns (expected_columns),
		.res_valid        (m_tvalid),
		.res_ready        (m_tready),
		.res              (res)
	);

	// Pack the result word onto the output bus, first field in the lowest bits.
	assign m_tdata = {5'd0, res.byte_offset, res.column_index, res.out_byte};
	assign m_tlast = res.record_done;
	assign m_tuser = {res.status, res.field_start};

endmodule
